// File: rtl/tksi_pkg.sv
`default_nettype none
package tksi_pkg;

	localparam int ENTRIES_DEF  = 10;
	localparam int TAG_BITS_DEF = 16;

	localparam int SCORE_W = 32;
	localparam int TAG_W   = 16;
	localparam int RANK_W  = 4;

	localparam logic REQ_SUBMIT = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [SCORE_W-1:0] score;
		logic [TAG_W-1:0]   tag;
		logic [RANK_W-1:0]  rank;
	} req_t;

	typedef struct packed {
		logic               accepted;
		logic [RANK_W-1:0]  rank_out;
		logic [SCORE_W-1:0] score_out;
		logic [TAG_W-1:0]   tag_out;
	} res_t;

endpackage
`default_nettype wire

// File: rtl/tksi_chan_if.sv
`default_nettype none
interface tksi_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/tksi_cell.sv
`default_nettype none
module tksi_cell
	import tksi_pkg::*;
#(
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                shift_en,
	input  wire logic [SCORE_W-1:0]  cand_score,
	input  wire logic [TAG_BITS-1:0] cand_tag,
	input  wire logic                up_gt,
	input  wire logic [SCORE_W-1:0]  up_score,
	input  wire logic [TAG_BITS-1:0] up_tag,
	output logic                     gt,
	output logic [SCORE_W-1:0]       score,
	output logic [TAG_BITS-1:0]      tag
);

	logic [SCORE_W-1:0]  score_q;
	logic [TAG_BITS-1:0] tag_q;

	// candidate beats this entry, so this entry moves down or is replaced
	assign gt    = cand_score > score_q;
	assign score = score_q;
	assign tag   = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
			tag_q   <= '0;
		end else if (shift_en && gt) begin
			if (up_gt) begin
				score_q <= up_score;
				tag_q   <= up_tag;
			end else begin
				score_q <= cand_score;
				tag_q   <= cand_tag;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/top_k_sorted_insert.sv
// Ranked top-k table of ENTRIES score/tag pairs, highest score at rank 0, cleared to zero
// by reset. A submit beat enters only when its score is strictly above the last entry; it
// lands below all entries of equal or higher score, lower entries move down one rank and
// the last one drops out. A read beat returns the pair at a rank (zeros past the table).
// Every beat yields exactly one result beat in the cycle after it is taken. The block
// takes one beat per cycle unless back-pressured: each cell compares the candidate against
// its own entry in parallel and loads from its upper neighbor or the candidate in the same
// cycle, and a single output register lets a new beat in while the last result is taken.
`default_nettype none
module top_k_sorted_insert
	import tksi_pkg::*;
#(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tksi_chan_if.sink    req_ch,
	tksi_chan_if.source  res_ch
);

	logic                take;
	logic                shift_en;
	logic [TAG_BITS-1:0] cand_tag;
	logic [TAG_BITS+TAG_W-1:0] cand_tag_wide;

	logic [ENTRIES-1:0]  gt;
	logic [ENTRIES-1:0]  land;
	logic [ENTRIES-1:0]  sel;
	logic [SCORE_W-1:0]  cell_score [ENTRIES];
	logic [TAG_BITS-1:0] cell_tag   [ENTRIES];

	logic [RANK_W-1:0]   land_rank;
	logic [SCORE_W-1:0]  rd_score;
	logic [TAG_BITS-1:0] rd_tag;
	logic [TAG_BITS+TAG_W-1:0] rd_tag_wide;
	logic [TAG_BITS+TAG_W-1:0] echo_tag_wide;

	res_t res_d;
	res_t res_q;
	logic res_valid_q;

	assign req_ch.ready = !res_valid_q || res_ch.ready;
	assign take         = req_ch.valid && req_ch.ready;
	assign shift_en     = take && (req_ch.data.req_type == REQ_SUBMIT);

	assign cand_tag_wide = {{TAG_BITS{1'b0}}, req_ch.data.tag};
	assign cand_tag      = cand_tag_wide[TAG_BITS-1:0];

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic                up_gt;
		logic [SCORE_W-1:0]  up_score;
		logic [TAG_BITS-1:0] up_tag;

		if (i == 0) begin : g_top
			assign up_gt    = 1'b0;
			assign up_score = '0;
			assign up_tag   = '0;
		end else begin : g_rest
			assign up_gt    = gt[i-1];
			assign up_score = cell_score[i-1];
			assign up_tag   = cell_tag[i-1];
		end

		tksi_cell #(
			.TAG_BITS (TAG_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (shift_en),
			.cand_score (req_ch.data.score),
			.cand_tag   (cand_tag),
			.up_gt      (up_gt),
			.up_score   (up_score),
			.up_tag     (up_tag),
			.gt         (gt[i]),
			.score      (cell_score[i]),
			.tag        (cell_tag[i])
		);

		assign land[i] = gt[i] && !up_gt;
		assign sel[i]  = ({{(32-RANK_W){1'b0}}, req_ch.data.rank} == 32'(i));
	end

	always_comb begin
		land_rank = '0;
		rd_score  = '0;
		rd_tag    = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			land_rank = land_rank | (land[i] ? RANK_W'(i) : '0);
			rd_score  = rd_score | (sel[i] ? cell_score[i] : '0);
			rd_tag    = rd_tag | (sel[i] ? cell_tag[i] : '0);
		end
	end

	assign rd_tag_wide   = {{TAG_W{1'b0}}, rd_tag};
	assign echo_tag_wide = {{TAG_W{1'b0}}, cand_tag};

	always_comb begin
		if (req_ch.data.req_type == REQ_SUBMIT) begin
			res_d.accepted  = gt[ENTRIES-1];
			res_d.rank_out  = land_rank;
			res_d.score_out = req_ch.data.score;
			res_d.tag_out   = echo_tag_wide[TAG_W-1:0];
		end else begin
			res_d.accepted  = 1'b0;
			res_d.rank_out  = req_ch.data.rank;
			res_d.score_out = rd_score;
			res_d.tag_out   = rd_tag_wide[TAG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign res_ch.valid = res_valid_q;
	assign res_ch.data  = res_q;

endmodule
`default_nettype wire
